// ===== rtl/mp4bhp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp4bhp_pkg - shared types and constants of the MP4 box header parser
// Payload structs, status codes, register indexes, phase encoding and the
// top-level box type whitelist.
// ----------------------------------------------------------------------------
package mp4bhp_pkg;

  // one input transfer: a stream byte and its end-of-data mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic [31:0] type_code;
    logic [63:0] size_total;
    logic [4:0]  header_length;
    logic [2:0]  status;
  } out_t;

  // configuration registers
  typedef struct packed {
    logic check_top_level_types;
    logic require_complete_box;
  } cfg_t;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_TYPES      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REQUIRE_COMPLETE = 1'd1;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SIZE_ZERO  = 3'd1;
  localparam logic [2:0] ST_TOO_SMALL  = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;
  localparam logic [2:0] ST_INCOMPLETE = 3'd6;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DROP    = 3'b100
  } phase_t;

  // header layout
  localparam logic [4:0]  SIZE_FIELD_BYTES = 5'd4;
  localparam logic [4:0]  HDR_LEN_SHORT    = 5'd8;
  localparam logic [4:0]  HDR_LEN_LONG     = 5'd16;
  localparam logic [63:0] SIZE_EXTENDED    = 64'd1;
  localparam logic [63:0] SIZE_LIMIT       = 64'h0000_0000_7FFF_FFFF;

  // four-character codes
  localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
  localparam logic [31:0] TYPE_PDIN = 32'h7064_696E;
  localparam logic [31:0] TYPE_BLOC = 32'h626C_6F63;
  localparam logic [31:0] TYPE_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] TYPE_MOOF = 32'h6D6F_6F66;
  localparam logic [31:0] TYPE_MFRA = 32'h6D66_7261;
  localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;
  localparam logic [31:0] TYPE_FREE = 32'h6672_6565;
  localparam logic [31:0] TYPE_SKIP = 32'h736B_6970;
  localparam logic [31:0] TYPE_META = 32'h6D65_7461;
  localparam logic [31:0] TYPE_MECO = 32'h6D65_636F;
  localparam logic [31:0] TYPE_STYP = 32'h7374_7970;
  localparam logic [31:0] TYPE_SIDX = 32'h7369_6478;
  localparam logic [31:0] TYPE_SSIX = 32'h7373_6978;
  localparam logic [31:0] TYPE_PRFT = 32'h7072_6674;

  function automatic logic in_top_level_list(input logic [31:0] t);
    logic r;
    unique case (t) inside
      TYPE_FTYP, TYPE_PDIN, TYPE_BLOC, TYPE_MOOV, TYPE_MOOF,
      TYPE_MFRA, TYPE_MDAT, TYPE_FREE, TYPE_SKIP, TYPE_META,
      TYPE_MECO, TYPE_STYP, TYPE_SIDX, TYPE_SSIX, TYPE_PRFT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mp4bhp_parse_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp4bhp_parse_core - input register and per-byte header parser
// Holds one byte in an input register, then updates the box state and forms
// at most one result in a single pass.
// ----------------------------------------------------------------------------
module mp4bhp_parse_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mp4bhp_pkg::cfg_t  cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mp4bhp_pkg::in_t   in_data,
  input  wire logic              buf_full,
  output logic                   res_push,
  output mp4bhp_pkg::out_t       res_data
);

  logic              held_valid;
  mp4bhp_pkg::in_t   held;
  logic              advance;

  mp4bhp_pkg::phase_t phase, phase_next;
  logic [4:0]        header_count, header_count_next;
  logic [63:0]       size_acc, size_acc_next;
  logic [31:0]       type_reg, type_reg_next;
  logic [63:0]       payload_rem, payload_rem_next;

  logic [4:0]        cnt_inc;
  logic              shift_size;
  logic [63:0]       nsize;
  logic [31:0]       ntype;
  logic              hdr_done;
  logic [2:0]        judge;
  logic [63:0]       rem_hdr;
  logic [63:0]       rem_dec;
  logic              clear;
  logic              res_valid;

  // item moves on when the result buffer has a free slot
  assign advance  = held_valid && !buf_full;
  assign in_stall = held_valid && buf_full;
  assign res_push = advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held <= in_data;
    end
  end

  // header byte placement
  assign cnt_inc    = header_count + 5'd1;
  assign shift_size = (header_count < mp4bhp_pkg::SIZE_FIELD_BYTES) ||
                      (header_count >= mp4bhp_pkg::HDR_LEN_SHORT);
  assign nsize = shift_size ? {size_acc[55:0], held.data_byte} : size_acc;
  assign ntype = shift_size ? type_reg : {type_reg[23:0], held.data_byte};
  assign hdr_done = ((cnt_inc == mp4bhp_pkg::HDR_LEN_SHORT) &&
                     (nsize != mp4bhp_pkg::SIZE_EXTENDED)) ||
                    (cnt_inc == mp4bhp_pkg::HDR_LEN_LONG);
  assign rem_hdr = nsize - {59'd0, cnt_inc};
  assign rem_dec = (payload_rem != 64'd0) ? payload_rem - 64'd1 : payload_rem;

  // first failing check wins
  always_comb begin
    if ((cnt_inc == mp4bhp_pkg::HDR_LEN_SHORT) && (nsize == 64'd0)) begin
      judge = mp4bhp_pkg::ST_SIZE_ZERO;
    end else if (nsize < {59'd0, cnt_inc}) begin
      judge = mp4bhp_pkg::ST_TOO_SMALL;
    end else if ((nsize > mp4bhp_pkg::SIZE_LIMIT) &&
                 (ntype != mp4bhp_pkg::TYPE_MDAT)) begin
      judge = mp4bhp_pkg::ST_TOO_LARGE;
    end else if (cfg.check_top_level_types && (ntype != mp4bhp_pkg::TYPE_MDAT) &&
                 !mp4bhp_pkg::in_top_level_list(ntype)) begin
      judge = mp4bhp_pkg::ST_BAD_TYPE;
    end else begin
      judge = mp4bhp_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    size_acc_next     = size_acc;
    type_reg_next     = type_reg;
    payload_rem_next  = payload_rem;
    clear             = 1'b0;
    res_valid         = 1'b0;
    res_data          = '0;
    unique case (phase)
      mp4bhp_pkg::PH_DROP: begin
        clear = held.end_of_data;
      end
      mp4bhp_pkg::PH_PAYLOAD: begin
        payload_rem_next = rem_dec;
        if (rem_dec == 64'd0) begin
          clear = 1'b1;
        end else if (held.end_of_data) begin
          clear = 1'b1;
          if (cfg.require_complete_box && (type_reg != mp4bhp_pkg::TYPE_MDAT)) begin
            res_valid = 1'b1;
            res_data  = '{type_reg, size_acc, header_count, mp4bhp_pkg::ST_INCOMPLETE};
          end
        end
      end
      default: begin
        // header phase; the unused code behaves the same
        phase_next        = mp4bhp_pkg::PH_HEADER;
        header_count_next = cnt_inc;
        size_acc_next     = nsize;
        type_reg_next     = ntype;
        if (hdr_done) begin
          res_valid = 1'b1;
          res_data  = '{ntype, nsize, cnt_inc, mp4bhp_pkg::ST_OK};
          if (judge != mp4bhp_pkg::ST_OK) begin
            res_data.status = judge;
            phase_next      = mp4bhp_pkg::PH_DROP;
            clear           = held.end_of_data;
          end else begin
            payload_rem_next = rem_hdr;
            if (rem_hdr == 64'd0) begin
              clear = 1'b1;
            end else if (held.end_of_data) begin
              clear = 1'b1;
              if (cfg.require_complete_box && (ntype != mp4bhp_pkg::TYPE_MDAT)) begin
                res_data.status = mp4bhp_pkg::ST_INCOMPLETE;
              end
            end else begin
              phase_next = mp4bhp_pkg::PH_PAYLOAD;
            end
          end
        end else if (held.end_of_data) begin
          res_valid = 1'b1;
          res_data  = '{32'd0, 64'd0, cnt_inc, mp4bhp_pkg::ST_TRUNCATED};
          clear     = 1'b1;
        end
      end
    endcase
    if (clear) begin
      phase_next        = mp4bhp_pkg::PH_HEADER;
      header_count_next = 5'd0;
      size_acc_next     = 64'd0;
      type_reg_next     = 32'd0;
      payload_rem_next  = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mp4bhp_pkg::PH_HEADER;
      header_count <= 5'd0;
      size_acc     <= 64'd0;
      type_reg     <= 32'd0;
      payload_rem  <= 64'd0;
    end else if (advance) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      size_acc     <= size_acc_next;
      type_reg     <= type_reg_next;
      payload_rem  <= payload_rem_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a long header keeps its count of 16 through payload and drop
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    header_count <= mp4bhp_pkg::HDR_LEN_LONG)
    else $error("header count beyond a full long header");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == mp4bhp_pkg::PH_PAYLOAD |-> payload_rem != 64'd0)
    else $error("payload phase with nothing left to skip");

  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    res_push && res_data.status == mp4bhp_pkg::ST_TRUNCATED |->
      res_data.header_length != 5'd0 && res_data.header_length < mp4bhp_pkg::HDR_LEN_LONG)
    else $error("truncated header result with bad length");
`endif

endmodule
`default_nettype wire

// ===== rtl/mp4bhp_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp4bhp_out_buf - two-entry result buffer
// Registers results so the parser keeps taking bytes while the receiver
// stalls, until both entries are taken.
// ----------------------------------------------------------------------------
module mp4bhp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mp4bhp_pkg::out_t  push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mp4bhp_pkg::out_t       out_data
);

  mp4bhp_pkg::out_t ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = ent[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result buffer count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/mp4_box_header_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp4_box_header_parser - MP4 (ISO base media) box header parser
// Walks a box stream byte by byte, reports each box header and skips payload.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel: one stream byte per transfer (in_valid / in_stall), with
//    end_of_data marking the last byte of a buffer.
//  - out channel: one transfer per completed header, truncated header or
//    incomplete box (out_valid / out_stall); most bytes give no result.
//  - cfg port: cfg_we writes cfg_data into register cfg_index at the edge;
//    write only while the block is idle.
// Timing: one byte per cycle while in_stall stays low. A byte is held in the
//  input register, then parsed in a single pass into the state registers and
//  the result buffer, from whose entry its result is offered to the receiver.
// Stalls: a two-entry result buffer absorbs a stalled receiver; in_stall
//  rises only once both entries are taken and a byte is waiting.
// Reset (rst, synchronous): empties both buffers, returns to expecting a
//  header, and sets both configuration bits to 1.
// ----------------------------------------------------------------------------
module mp4_box_header_parser (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire mp4bhp_pkg::in_t                    in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output mp4bhp_pkg::out_t                        out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mp4bhp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic                               cfg_data
);

  mp4bhp_pkg::cfg_t cfg;
  logic             buf_full;
  logic             res_push;
  mp4bhp_pkg::out_t res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_top_level_types <= 1'b1;
      cfg.require_complete_box  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mp4bhp_pkg::REG_CHECK_TYPES:      cfg.check_top_level_types <= cfg_data;
        mp4bhp_pkg::REG_REQUIRE_COMPLETE: cfg.require_complete_box  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, box state and single-pass parse
  mp4bhp_parse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .buf_full (buf_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // result buffer towards the receiver
  mp4bhp_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== bench/tb_mp4_box_header_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mp4_box_header_parser - self-checking bench for the MP4 box header parser
// Feeds byte streams of box headers, payloads and noise through the
// valid/stall input channel. A behavioural parser in the bench predicts every
// result not typed in, and each result transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_mp4_box_header_parser;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000; // cycles without any transfer
  localparam int PHASE_ITEMS    = 170;
  localparam int NUM_PHASES     = 6;

  // typed-in results of the opening script
  localparam mp4bhp_pkg::out_t NO_RESULT = '0;
  localparam mp4bhp_pkg::out_t R_ZERO_FTYP = '{
    type_code: mp4bhp_pkg::TYPE_FTYP, size_total: 64'd0,
    header_length: mp4bhp_pkg::HDR_LEN_SHORT, status: mp4bhp_pkg::ST_SIZE_ZERO};
  localparam mp4bhp_pkg::out_t R_TRUNC_ONE = '{
    type_code: 32'd0, size_total: 64'd0,
    header_length: 5'd1, status: mp4bhp_pkg::ST_TRUNCATED};
  localparam mp4bhp_pkg::out_t R_MOOV_CUT = '{
    type_code: mp4bhp_pkg::TYPE_MOOV, size_total: 64'd9,
    header_length: mp4bhp_pkg::HDR_LEN_SHORT, status: mp4bhp_pkg::ST_INCOMPLETE};
  localparam mp4bhp_pkg::out_t R_HUGE_ABCD = '{
    type_code: 32'h6162_6364, size_total: 64'hFFFF_FFFF,
    header_length: mp4bhp_pkg::HDR_LEN_SHORT, status: mp4bhp_pkg::ST_TOO_LARGE};

  typedef struct {
    logic [7:0]       data_byte;
    bit               eod;
    bit               typed;   // result below is taken as is
    mp4bhp_pkg::out_t res;
  } script_row_t;

  // opening script: extremes of the byte, both end marks, the status ladder
  script_row_t opening_script [26] = '{
    // size zero, header finished on the end-of-data byte
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h66, 1'b0, 1'b0, NO_RESULT}, '{8'h74, 1'b0, 1'b0, NO_RESULT},
    '{8'h79, 1'b0, 1'b0, NO_RESULT}, '{8'h70, 1'b1, 1'b1, R_ZERO_FTYP},
    // one-byte truncated header
    '{8'h00, 1'b1, 1'b1, R_TRUNC_ONE},
    // moov with one payload byte left, cut off by end of data
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h09, 1'b0, 1'b0, NO_RESULT},
    '{8'h6D, 1'b0, 1'b0, NO_RESULT}, '{8'h6F, 1'b0, 1'b0, NO_RESULT},
    '{8'h6F, 1'b0, 1'b0, NO_RESULT}, '{8'h76, 1'b1, 1'b1, R_MOOV_CUT},
    // all-ones size on an unknown type: too large wins over bad type
    '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h61, 1'b0, 1'b0, NO_RESULT}, '{8'h62, 1'b0, 1'b0, NO_RESULT},
    '{8'h63, 1'b0, 1'b0, NO_RESULT}, '{8'h64, 1'b0, 1'b1, R_HUGE_ABCD},
    // dropped, end of data leaves drop mode quietly
    '{8'hFF, 1'b1, 1'b0, NO_RESULT}
  };

  // per-phase register settings and idling
  bit phase_check_types [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  bit phase_need_whole  [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  int phase_send_idle   [NUM_PHASES] = '{35, 35, 63, 63, 0, 0};
  int phase_recv_stall  [NUM_PHASES] = '{63, 63, 35, 35, 0, 0};

  logic [31:0] top_level_types [15] = '{
    mp4bhp_pkg::TYPE_FTYP, mp4bhp_pkg::TYPE_PDIN, mp4bhp_pkg::TYPE_BLOC,
    mp4bhp_pkg::TYPE_MOOV, mp4bhp_pkg::TYPE_MOOF, mp4bhp_pkg::TYPE_MFRA,
    mp4bhp_pkg::TYPE_MDAT, mp4bhp_pkg::TYPE_FREE, mp4bhp_pkg::TYPE_SKIP,
    mp4bhp_pkg::TYPE_META, mp4bhp_pkg::TYPE_MECO, mp4bhp_pkg::TYPE_STYP,
    mp4bhp_pkg::TYPE_SIDX, mp4bhp_pkg::TYPE_SSIX, mp4bhp_pkg::TYPE_PRFT
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  mp4bhp_pkg::in_t                    in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  mp4bhp_pkg::out_t                   out_data;
  logic                               cfg_we = 1'b0;
  logic [mp4bhp_pkg::CFG_INDEX_W-1:0] cfg_index = mp4bhp_pkg::REG_CHECK_TYPES;
  logic                               cfg_data = 1'b0;

  mp4_box_header_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioural parser: the bench's own copy of the block state
  // --------------------------------------------------------------------------
  bit                 chk_types     = 1'b1;
  bit                 need_complete = 1'b1;
  mp4bhp_pkg::phase_t box_phase     = mp4bhp_pkg::PH_HEADER;
  logic [4:0]         hdr_count     = '0;
  logic [63:0]        size_acc      = '0;
  logic [31:0]        type_reg      = '0;
  logic [63:0]        payload_left  = '0;

  mp4bhp_pkg::out_t pending_headers [$];   // predicted result transfers, oldest first
  int               fail_count = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_req   = 1'b0;   // raised by stimulus, served by receiver
  bit pressure_taken = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic [7:0] stream_chunk [$];

  function automatic bit is_top_level(input logic [31:0] t);
    bit hit;
    hit = 1'b0;
    foreach (top_level_types[i])
      if (top_level_types[i] == t) hit = 1'b1;
    return hit;
  endfunction

  function automatic void clear_box();
    box_phase    = mp4bhp_pkg::PH_HEADER;
    hdr_count    = '0;
    size_acc     = '0;
    type_reg     = '0;
    payload_left = '0;
  endfunction

  // first failing check sets the status
  function automatic logic [2:0] judge_header(input logic [63:0] size, input logic [4:0] hl);
    logic [2:0] st;
    if (hl == mp4bhp_pkg::HDR_LEN_SHORT && size == 64'd0)
      st = mp4bhp_pkg::ST_SIZE_ZERO;
    else if (size < {59'd0, hl})
      st = mp4bhp_pkg::ST_TOO_SMALL;
    else if (size > mp4bhp_pkg::SIZE_LIMIT && type_reg != mp4bhp_pkg::TYPE_MDAT)
      st = mp4bhp_pkg::ST_TOO_LARGE;
    else if (chk_types && type_reg != mp4bhp_pkg::TYPE_MDAT && !is_top_level(type_reg))
      st = mp4bhp_pkg::ST_BAD_TYPE;
    else
      st = mp4bhp_pkg::ST_OK;
    return st;
  endfunction

  // advance the state by one accepted byte; returns 1 when a result is due
  function automatic bit parse_byte(input mp4bhp_pkg::in_t item,
                                    output mp4bhp_pkg::out_t res);
    bit         found;
    logic [2:0] st;
    found = 1'b0;
    res   = '0;
    case (box_phase)
      mp4bhp_pkg::PH_DROP: begin
        if (item.end_of_data) clear_box();
      end
      mp4bhp_pkg::PH_PAYLOAD: begin
        if (payload_left != 64'd0) payload_left = payload_left - 64'd1;
        if (payload_left == 64'd0) begin
          clear_box();
        end else if (item.end_of_data) begin
          // box cut off inside its payload
          if (need_complete && type_reg != mp4bhp_pkg::TYPE_MDAT) begin
            res   = '{type_reg, size_acc, hdr_count, mp4bhp_pkg::ST_INCOMPLETE};
            found = 1'b1;
          end
          clear_box();
        end
      end
      default: begin
        box_phase = mp4bhp_pkg::PH_HEADER;
        if (hdr_count < mp4bhp_pkg::SIZE_FIELD_BYTES ||
            hdr_count >= mp4bhp_pkg::HDR_LEN_SHORT)
          size_acc = {size_acc[55:0], item.data_byte};
        else
          type_reg = {type_reg[23:0], item.data_byte};
        hdr_count = hdr_count + 5'd1;
        if ((hdr_count == mp4bhp_pkg::HDR_LEN_SHORT &&
             size_acc != mp4bhp_pkg::SIZE_EXTENDED) ||
            hdr_count == mp4bhp_pkg::HDR_LEN_LONG) begin
          st    = judge_header(size_acc, hdr_count);
          res   = '{type_reg, size_acc, hdr_count, st};
          found = 1'b1;
          if (st != mp4bhp_pkg::ST_OK) begin
            box_phase = mp4bhp_pkg::PH_DROP;
            if (item.end_of_data) clear_box();
          end else begin
            payload_left = size_acc - {59'd0, hdr_count};
            if (payload_left == 64'd0) begin
              clear_box();
            end else if (item.end_of_data) begin
              // header finished on the last byte with payload still owed
              if (need_complete && type_reg != mp4bhp_pkg::TYPE_MDAT)
                res.status = mp4bhp_pkg::ST_INCOMPLETE;
              clear_box();
            end else begin
              box_phase = mp4bhp_pkg::PH_PAYLOAD;
            end
          end
        end else if (item.end_of_data) begin
          res   = '{32'd0, 64'd0, hdr_count, mp4bhp_pkg::ST_TRUNCATED};
          found = 1'b1;
          clear_box();
        end
      end
    endcase
    return found;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, one long hold-off, field-by-field check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !pressure_taken) begin
      // sit on the output so the two-entry buffer fills and backs up
      out_stall      <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      pressure_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_header(input mp4bhp_pkg::out_t got);
    mp4bhp_pkg::out_t want;
    if (pending_headers.size() == 0) begin
      $error("result transfer with nothing predicted: type %h size %h len %0d status %0d",
             got.type_code, got.size_total, got.header_length, got.status);
      fail_count++;
    end else begin
      want = pending_headers.pop_front();
      if (got.type_code != want.type_code) begin
        $error("type_code: expected %h, got %h", want.type_code, got.type_code);
        fail_count++;
      end
      if (got.size_total != want.size_total) begin
        $error("size_total: expected %h, got %h", want.size_total, got.size_total);
        fail_count++;
      end
      if (got.header_length != want.header_length) begin
        $error("header_length: expected %0d, got %0d", want.header_length, got.header_length);
        fail_count++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_header(out_data);
  end

  // watchdog: too long without a transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one byte, hold it until the transfer, then update the prediction.
  // A typed row's result replaces the predicted one.
  task automatic offer_byte(input mp4bhp_pkg::in_t item, input bit typed,
                            input mp4bhp_pkg::out_t typed_res);
    mp4bhp_pkg::out_t res;
    bit               due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    due = parse_byte(item, res);
    if (typed)
      pending_headers.push_back(typed_res);
    else if (due)
      pending_headers.push_back(res);
  endtask

  // Append one box to stream_chunk. open_ended is set when the declared
  // payload is too long to send, so the buffer must end inside it.
  task automatic append_box(output bit open_ended);
    logic [31:0] tcode;
    logic [63:0] size;
    logic [63:0] owed;
    logic [31:0] hi;
    bit          extended;
    int          pick;
    int          k;
    int          n;
    pick = int'($urandom_range(0, 99));
    if (pick < 70)      tcode = top_level_types[$urandom_range(0, 14)];
    else if (pick < 80) tcode = mp4bhp_pkg::TYPE_MDAT;
    else                tcode = $urandom;
    extended = 1'b0;
    pick = int'($urandom_range(0, 99));
    if (pick < 60) begin
      size = 64'($urandom_range(8, 40));
    end else if (pick < 65) begin
      size = 64'd0;
    end else if (pick < 70) begin
      size = 64'($urandom_range(2, 7));                 // 1 would mean extended
    end else if (pick < 75) begin
      size = {32'd0, 32'h8000_0000 | $urandom};         // beyond the 31-bit limit
    end else if (pick < 90) begin
      extended = 1'b1;
      size     = 64'($urandom_range(16, 48));
    end else if (pick < 94) begin
      extended = 1'b1;
      size     = 64'($urandom_range(0, 15));
    end else begin
      extended = 1'b1;
      hi       = $urandom;
      if (hi == 32'd0) hi = 32'd1;
      size     = {hi, 32'($urandom)};
    end
    if (extended) begin
      for (k = 3; k >= 0; k--) stream_chunk.push_back(mp4bhp_pkg::SIZE_EXTENDED[8*k +: 8]);
      for (k = 3; k >= 0; k--) stream_chunk.push_back(tcode[8*k +: 8]);
      for (k = 7; k >= 0; k--) stream_chunk.push_back(size[8*k +: 8]);
      owed = (size > 64'd16) ? size - 64'd16 : 64'd0;
    end else begin
      for (k = 3; k >= 0; k--) stream_chunk.push_back(size[8*k +: 8]);
      for (k = 3; k >= 0; k--) stream_chunk.push_back(tcode[8*k +: 8]);
      owed = (size > 64'd8) ? size - 64'd8 : 64'd0;
    end
    open_ended = (owed > 64'd64);
    n = open_ended ? int'($urandom_range(0, 20)) : int'(owed);
    for (k = 0; k < n; k++) stream_chunk.push_back(8'($urandom_range(0, 255)));
  endtask

  // One buffer: mostly well-formed boxes, sometimes cut short, sometimes
  // plain noise; its last byte carries the end-of-data mark.
  task automatic send_buffer(inout int sent);
    mp4bhp_pkg::in_t item;
    bit              open_ended;
    int              boxes;
    int              keep;
    int              i;
    logic [7:0]      dropped;
    stream_chunk.delete();
    if ($urandom_range(0, 99) < 10) begin
      keep = int'($urandom_range(1, 24));
      for (i = 0; i < keep; i++) stream_chunk.push_back(8'($urandom_range(0, 255)));
    end else begin
      boxes      = int'($urandom_range(1, 4));
      open_ended = 1'b0;
      for (i = 0; i < boxes && !open_ended; i++) append_box(open_ended);
      if ($urandom_range(0, 99) < 25) begin
        keep = int'($urandom_range(1, stream_chunk.size()));
        while (stream_chunk.size() > keep) dropped = stream_chunk.pop_back();
      end
    end
    for (i = 0; i < stream_chunk.size(); i++) begin
      item.data_byte   = stream_chunk[i];
      item.end_of_data = (i == stream_chunk.size() - 1);
      offer_byte(item, 1'b0, NO_RESULT);
      sent++;
    end
  endtask

  // wait until every predicted header is out and the pipe has emptied
  task automatic settle();
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input bit check_types, input bit need_whole);
    cfg_we    <= 1'b1;
    cfg_index <= mp4bhp_pkg::REG_CHECK_TYPES;
    cfg_data  <= check_types;
    @(posedge clk);
    chk_types  = check_types;
    cfg_index <= mp4bhp_pkg::REG_REQUIRE_COMPLETE;
    cfg_data  <= need_whole;
    @(posedge clk);
    need_complete = need_whole;
    cfg_we       <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Run: opening script with reset settings, then random phases
  // --------------------------------------------------------------------------
  initial begin
    mp4bhp_pkg::in_t item;
    int              r;
    int              p;
    int              sent;
    send_idle_pct  = phase_send_idle[0];
    recv_stall_pct = phase_recv_stall[0];
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < 26; r++) begin
      item.data_byte   = opening_script[r].data_byte;
      item.end_of_data = opening_script[r].eod;
      offer_byte(item, opening_script[r].typed, opening_script[r].res);
    end
    in_valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_config(phase_check_types[p], phase_need_whole[p]);
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      // last phase: no idling, plus one long hold-off on the result side
      if (p == NUM_PHASES - 1) pressure_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) send_buffer(sent);
      in_valid <= 1'b0;
    end

    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_headers.size() != 0) begin
      $error("%0d predicted results never arrived", pending_headers.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
